FILE: rtl/h264aus_pkg.sv
// ----------------------------------------------------------------------------
// h264aus_pkg
// Shared types and constants for the access unit splitter.
// ----------------------------------------------------------------------------
package h264aus_pkg;

  // Item kind codes
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  localparam int unsigned LENGTH_BITS_DEF = 24;
  localparam int unsigned OUT_LEN_BITS    = 24;
  localparam int unsigned WINDOW_BITS     = 40;

  localparam logic [31:0] START_CODE        = 32'h0000_0001;
  localparam logic [4:0]  NAL_TYPE_MASK     = 5'h1F;
  localparam int unsigned FIRST_MB_BIT      = 7;
  localparam logic [4:0]  VCL_TYPE_MIN      = 5'd1;
  localparam logic [4:0]  VCL_TYPE_MAX      = 5'd5;
  localparam int unsigned BYTES_AFTER_START = 6;
  localparam logic [OUT_LEN_BITS-1:0] OUT_MAX = '1;
  localparam logic [WINDOW_BITS-1:0]  WINDOW_RESET = '1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [OUT_LEN_BITS-1:0] au_length;
    logic                    length_overflow;
    logic [4:0]              next_nal_type;
  } out_item_t;

  // Parser result toward the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

FILE: rtl/h264aus_in_stage.sv
// ----------------------------------------------------------------------------
// h264aus_in_stage
// Input register: captures one item and holds it until the parser advances.
// ----------------------------------------------------------------------------
module h264aus_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  h264aus_pkg::in_item_t in_item,
  input  logic                adv,
  output logic                held_valid,
  output h264aus_pkg::in_item_t held_item
);

  logic                  valid_r;
  logic                  valid_nxt;
  h264aus_pkg::in_item_t item_r;
  logic                  load;

  assign in_stall = valid_r && !adv;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      item_r <= in_item;
    end
  end

  assign held_valid = valid_r;
  assign held_item  = item_r;

endmodule

FILE: rtl/h264aus_parser.sv
// ----------------------------------------------------------------------------
// h264aus_parser
// Start code window, VCL tracking and access unit byte counter.
// ----------------------------------------------------------------------------
module h264aus_parser #(
  parameter int unsigned LENGTH_BITS = h264aus_pkg::LENGTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  h264aus_pkg::in_item_t item,
  output h264aus_pkg::res_t     res
);

  localparam int unsigned CmpW = (LENGTH_BITS > h264aus_pkg::OUT_LEN_BITS) ?
                                 LENGTH_BITS : h264aus_pkg::OUT_LEN_BITS;
  localparam logic [LENGTH_BITS-1:0] RestartCnt =
    LENGTH_BITS'(h264aus_pkg::BYTES_AFTER_START);

  logic [h264aus_pkg::WINDOW_BITS-1:0] win_r;
  logic                                prev_vcl_r;
  logic [LENGTH_BITS-1:0]              cnt_r;
  logic                                sat_r;

  logic                   cnt_max;
  logic [LENGTH_BITS-1:0] cnt_inc;
  logic                   sat_inc;
  logic                   sc_hit;
  logic [4:0]             nal_type;
  logic                   first_mb;
  logic                   is_vcl;
  logic                   ends;
  logic [LENGTH_BITS-1:0] len_full;
  logic [CmpW-1:0]        len_ext;
  logic                   ovf;
  logic                   restart;

  always_comb begin
    restart  = (item.kind == h264aus_pkg::KIND_RESTART);
    cnt_max  = (cnt_r == '1);
    cnt_inc  = cnt_max ? cnt_r : cnt_r + 1'b1;
    sat_inc  = sat_r | cnt_max;
    sc_hit   = (win_r[39:8] == h264aus_pkg::START_CODE);
    nal_type = win_r[4:0] & h264aus_pkg::NAL_TYPE_MASK;
    first_mb = item.data_byte[h264aus_pkg::FIRST_MB_BIT];
    is_vcl   = (nal_type >= h264aus_pkg::VCL_TYPE_MIN) &&
               (nal_type <= h264aus_pkg::VCL_TYPE_MAX);
    ends     = sc_hit && prev_vcl_r && (!is_vcl || first_mb);
    // Length up to the new start code, clamped at zero
    len_full = (cnt_inc >= RestartCnt) ? cnt_inc - RestartCnt : '0;
    len_ext  = CmpW'(len_full);
    ovf      = sat_inc || (len_ext > CmpW'(h264aus_pkg::OUT_MAX));

    res.valid                = adv && !restart && ends;
    res.item.au_length       = ovf ? h264aus_pkg::OUT_MAX :
                                     len_ext[h264aus_pkg::OUT_LEN_BITS-1:0];
    res.item.length_overflow = ovf;
    res.item.next_nal_type   = nal_type;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= h264aus_pkg::WINDOW_RESET;
      prev_vcl_r <= 1'b0;
      cnt_r      <= '0;
      sat_r      <= 1'b0;
    end else if (adv) begin
      if (restart) begin
        win_r      <= h264aus_pkg::WINDOW_RESET;
        prev_vcl_r <= 1'b0;
        cnt_r      <= '0;
        sat_r      <= 1'b0;
      end else begin
        win_r <= {win_r[31:0], item.data_byte};
        if (sc_hit) begin
          prev_vcl_r <= is_vcl;
        end
        if (ends) begin
          cnt_r <= RestartCnt;
          sat_r <= 1'b0;
        end else begin
          cnt_r <= cnt_inc;
          sat_r <= sat_inc;
        end
      end
    end
  end

  a_res_needs_vcl : assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (adv && prev_vcl_r && sc_hit))
    else $error("boundary reported without a preceding VCL start code");

  a_restart_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && restart) |=> (cnt_r == '0 && !sat_r && !prev_vcl_r))
    else $error("restart did not clear parser state");

  a_boundary_reload : assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> (cnt_r == RestartCnt && !sat_r))
    else $error("counter not reloaded after boundary");

  a_sat_at_max : assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (cnt_r == '1))
    else $error("saturation flag set below counter maximum");

endmodule

FILE: rtl/h264aus_out_reg.sv
// ----------------------------------------------------------------------------
// h264aus_out_reg
// Result register: holds a finished item until the consumer takes it.
// ----------------------------------------------------------------------------
module h264aus_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  h264aus_pkg::res_t      res,
  output logic                   room,
  output logic                   out_valid,
  input  logic                   out_stall,
  output h264aus_pkg::out_item_t out_item
);

  logic                   valid_r;
  logic                   valid_nxt;
  h264aus_pkg::out_item_t item_r;

  assign room = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (res.valid) begin
      item_r <= res.item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> room)
    else $error("result loaded while a stalled item is held");

endmodule

FILE: rtl/h264aus_core_top_note.sv
// ----------------------------------------------------------------------------
// h264aus_win_check
// Port-level checker for the result channel: handshake and saturated length.
// ----------------------------------------------------------------------------
module h264aus_win_check (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input h264aus_pkg::out_item_t out_item
);

  a_valid_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result valid dropped while stalled");

  a_sat_len : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.length_overflow) |->
      (out_item.au_length == h264aus_pkg::OUT_MAX))
    else $error("overflowed length not reported as maximum");

endmodule

FILE: rtl/h264_access_unit_splitter_core.sv
// ----------------------------------------------------------------------------
// h264_access_unit_splitter_core
// Splits an H.264 Annex B byte stream into access units and reports the
// byte length of each finished unit together with the next NAL type.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  --------+--------------------------------+---------------------------------
//  input   | in_valid, in_stall, in_item    | kind, data_byte
//  result  | out_valid, out_stall, out_item | au_length, length_overflow,
//          |                                |   next_nal_type
//
//  One byte per clock while the result register has room: an item waits in
//  the input register and is parsed on the way into the result register,
//  which holds its result. Synchronous active-low reset clears the window to
//  all 0xFF and the counter to zero. A stalled result holds the parser; the
//  input register still takes one more item while the result waits.
// ----------------------------------------------------------------------------
module h264_access_unit_splitter_core #(
  parameter int unsigned LENGTH_BITS = h264aus_pkg::LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  h264aus_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output h264aus_pkg::out_item_t out_item
);

  logic                  held_valid;
  h264aus_pkg::in_item_t held_item;
  logic                  room;
  logic                  adv;
  h264aus_pkg::res_t     res;

  // Advance the held item whenever the result register has room; an item
  // that yields no result still advances, so a stalled output only blocks
  // once something is actually waiting there.
  assign adv = held_valid && room;

  h264aus_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .adv        (adv),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // Window, VCL history and length counter update only on advance.
  h264aus_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (held_item),
    .res   (res)
  );

  h264aus_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  h264aus_win_check u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
